// ===== sv/acr_pkg.sv =====
// ----------------------------------------------------------------------------
// acr_pkg: shared types and constant tables of the AT command responder
// Command texts and lengths, response codes, the response text ROM and the
// structs that travel between the front end, the queue and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package acr_pkg;

	typedef logic [7:0] byte_t;

	localparam int    CMD_NUM  = 6;
	localparam int    CMD_MAXL = 7;
	localparam logic [3:0] POS_MAX = 4'd15;
	localparam byte_t CH_CR    = 8'd13;
	localparam byte_t CH_LF    = 8'd10;
	localparam byte_t CH_NUL   = 8'd0;

	// response selected for a line
	typedef enum logic [2:0] {
		RSP_OK,
		RSP_ERROR,
		RSP_IDENT,
		RSP_CPIN,
		RSP_COPS
	} rsp_code_t;

	// command texts, padded with NUL past their length
	localparam byte_t CMD_TEXT [0:CMD_NUM-1][0:CMD_MAXL-1] = '{
		'{8'd65, 8'd84, 8'd0,  8'd0,  8'd0,  8'd0,  8'd0},
		'{8'd65, 8'd84, 8'd69, 8'd48, 8'd0,  8'd0,  8'd0},
		'{8'd65, 8'd84, 8'd69, 8'd49, 8'd0,  8'd0,  8'd0},
		'{8'd65, 8'd84, 8'd73, 8'd0,  8'd0,  8'd0,  8'd0},
		'{8'd65, 8'd84, 8'd43, 8'd67, 8'd80, 8'd73, 8'd78},
		'{8'd65, 8'd84, 8'd43, 8'd67, 8'd79, 8'd80, 8'd83}
	};
	localparam logic [3:0] CMD_LEN [0:CMD_NUM-1] = '{4'd2, 4'd4, 4'd4, 4'd3, 4'd7, 4'd7};
	localparam rsp_code_t CMD_RSP [0:CMD_NUM-1] =
		'{RSP_OK, RSP_OK, RSP_OK, RSP_IDENT, RSP_CPIN, RSP_COPS};

	// response text ROM: OK, ERROR, identification, pin status, operator
	localparam int ROM_DEPTH = 109;
	typedef logic [$clog2(ROM_DEPTH)-1:0] rom_ptr_t;

	localparam byte_t RSP_ROM [0:ROM_DEPTH-1] = '{
		8'd79, 8'd75,
		8'd69, 8'd82, 8'd82, 8'd79, 8'd82,
		8'd77, 8'd97, 8'd110, 8'd117, 8'd102, 8'd97, 8'd99, 8'd116, 8'd117,
		8'd114, 8'd101, 8'd114, 8'd58, 8'd32,
		8'd77, 8'd121, 8'd83, 8'd101, 8'd114, 8'd118, 8'd101, 8'd114, 8'd13,
		8'd77, 8'd111, 8'd100, 8'd101, 8'd108, 8'd58, 8'd32,
		8'd86, 8'd105, 8'd114, 8'd116, 8'd117, 8'd97, 8'd108, 8'd77, 8'd111,
		8'd100, 8'd101, 8'd109, 8'd13,
		8'd82, 8'd101, 8'd118, 8'd105, 8'd115, 8'd105, 8'd111, 8'd110, 8'd58,
		8'd32, 8'd49, 8'd46, 8'd48, 8'd13,
		8'd79, 8'd75,
		8'd43, 8'd67, 8'd80, 8'd73, 8'd78, 8'd58, 8'd32, 8'd82, 8'd69, 8'd65,
		8'd68, 8'd89, 8'd13, 8'd79, 8'd75,
		8'd43, 8'd67, 8'd79, 8'd80, 8'd83, 8'd58, 8'd32, 8'd48, 8'd44, 8'd48,
		8'd44, 8'd34,
		8'd86, 8'd105, 8'd114, 8'd116, 8'd117, 8'd97, 8'd108, 8'd78, 8'd101,
		8'd116,
		8'd34, 8'd44, 8'd55, 8'd13, 8'd79, 8'd75
	};

	// first ROM entry of a response
	function automatic rom_ptr_t rsp_start(rsp_code_t code);
		rom_ptr_t p;
		unique case (code)
			RSP_OK:    p = rom_ptr_t'(0);
			RSP_ERROR: p = rom_ptr_t'(2);
			RSP_IDENT: p = rom_ptr_t'(7);
			RSP_CPIN:  p = rom_ptr_t'(66);
			RSP_COPS:  p = rom_ptr_t'(81);
			default:   p = rom_ptr_t'(2);
		endcase
		return p;
	endfunction

	// last ROM entry of a response
	function automatic rom_ptr_t rsp_end(rsp_code_t code);
		rom_ptr_t p;
		unique case (code)
			RSP_OK:    p = rom_ptr_t'(1);
			RSP_ERROR: p = rom_ptr_t'(6);
			RSP_IDENT: p = rom_ptr_t'(65);
			RSP_CPIN:  p = rom_ptr_t'(80);
			RSP_COPS:  p = rom_ptr_t'(108);
			default:   p = rom_ptr_t'(6);
		endcase
		return p;
	endfunction

	// queue between front and back end
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// one pending response
	typedef struct packed {
		logic      valid;
		rsp_code_t code;
	} acr_job_t;

	// back end sequencer
	typedef enum logic [1:0] {
		BK_IDLE,
		BK_TEXT,
		BK_CR,
		BK_LF
	} bk_state_t;

endpackage

`default_nettype wire

// ===== sv/at_rx_if.sv =====
// ----------------------------------------------------------------------------
// at_rx_if: received byte channel
// Valid/ready channel carrying one received serial byte per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface at_rx_if;
	import acr_pkg::*;

	logic  valid;
	logic  ready;
	byte_t rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ===== sv/at_tx_if.sv =====
// ----------------------------------------------------------------------------
// at_tx_if: response byte channel
// Valid/ready channel carrying one response byte per item and a last flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface at_tx_if;
	import acr_pkg::*;

	logic  valid;
	logic  ready;
	byte_t tx_byte;
	logic  tx_last;

	modport source (output valid, output tx_byte, output tx_last, input ready);
	modport sink   (input valid, input tx_byte, input tx_last, output ready);
endinterface

`default_nettype wire

// ===== sv/acr_front.sv =====
// ----------------------------------------------------------------------------
// acr_front: line matcher
// Takes one byte per cycle while the queue is not full, narrows the command
// candidates on the fly and posts the selected response to the queue on CR.
// ----------------------------------------------------------------------------
`default_nettype none

module acr_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	at_rx_if.sink                 rx,
	input  wire logic             full,
	output acr_pkg::acr_job_t     push
);
	import acr_pkg::*;

	logic [CMD_NUM-1:0] flags_q;
	logic [3:0]         pos_q;
	logic               ended_q;

	logic [CMD_NUM-1:0] keep;
	rsp_code_t          code;
	logic               accept;
	logic               is_cr;

	assign rx.ready = !full;
	assign accept   = rx.valid && rx.ready;
	assign is_cr    = (rx.rx_byte == CH_CR);

	// candidates that survive this byte
	always_comb begin
		for (int i = 0; i < CMD_NUM; i++) begin
			keep[i] = flags_q[i] && (pos_q < CMD_LEN[i]) &&
			          (CMD_TEXT[i][pos_q[2:0]] == rx.rx_byte);
		end
	end

	// first command that is still a candidate and fully matched
	always_comb begin
		code = RSP_ERROR;
		for (int i = CMD_NUM - 1; i >= 0; i--) begin
			if (flags_q[i] && (CMD_LEN[i] == pos_q)) begin
				code = CMD_RSP[i];
			end
		end
	end

	assign push.valid = accept && is_cr;
	assign push.code  = code;

	// line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '1;
			pos_q   <= '0;
			ended_q <= 1'b0;
		end else if (accept) begin
			if (is_cr) begin
				flags_q <= '1;
				pos_q   <= '0;
				ended_q <= 1'b0;
			end else if (!ended_q) begin
				if (rx.rx_byte == CH_NUL) begin
					ended_q <= 1'b1;
				end else begin
					flags_q <= keep;
					if (pos_q != POS_MAX) begin
						pos_q <= pos_q + 4'd1;
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/acr_queue.sv =====
// ----------------------------------------------------------------------------
// acr_queue: response queue
// Short queue of pending responses between the line matcher and the
// response sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module acr_queue (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  acr_pkg::acr_job_t push,
	input  wire logic         pop,
	output acr_pkg::acr_job_t head,
	output logic              full
);
	import acr_pkg::*;

	rsp_code_t          mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_q;
	logic [QPTR_W-1:0]  rd_q;
	logic [QCNT_W-1:0]  cnt_q;
	logic               do_pop;

	assign full       = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign head.valid = (cnt_q != '0);
	assign head.code  = mem_q[rd_q];
	assign do_pop     = pop && head.valid;

	// storage
	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_q] <= push.code;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push.valid) begin
				wr_q <= wr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			if (push.valid && !do_pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (do_pop && !push.valid) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/acr_back.sv =====
// ----------------------------------------------------------------------------
// acr_back: response sequencer
// Walks the response text ROM for one queued response, then appends CR LF,
// through an output register that holds under back pressure.
// ----------------------------------------------------------------------------
`default_nettype none

module acr_back (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  acr_pkg::acr_job_t head,
	output logic              pop,
	at_tx_if.source           tx
);
	import acr_pkg::*;

	bk_state_t state_q;
	bk_state_t state_d;
	rom_ptr_t  ptr_q;
	rom_ptr_t  end_q;
	logic      valid_q;
	byte_t     byte_q;
	logic      last_q;

	logic      produce;
	logic      emit;
	byte_t     emit_byte;
	logic      emit_last;

	assign produce    = !valid_q || tx.ready;
	assign tx.valid   = valid_q;
	assign tx.tx_byte = byte_q;
	assign tx.tx_last = last_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: if (head.valid) state_d = BK_TEXT;
			BK_TEXT: if (produce && (ptr_q == end_q)) state_d = BK_CR;
			BK_CR:   if (produce) state_d = BK_LF;
			BK_LF:   if (produce) state_d = BK_IDLE;
			default: state_d = BK_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		pop       = 1'b0;
		emit      = 1'b0;
		emit_byte = CH_CR;
		emit_last = 1'b0;
		unique case (state_q)
			BK_IDLE: pop = head.valid;
			BK_TEXT: begin
				emit      = produce;
				emit_byte = RSP_ROM[ptr_q];
			end
			BK_CR: begin
				emit      = produce;
				emit_byte = CH_CR;
			end
			BK_LF: begin
				emit      = produce;
				emit_byte = CH_LF;
				emit_last = 1'b1;
			end
			default: pop = 1'b0;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (produce) begin
				valid_q <= emit;
			end
		end
	end

	// rom pointer and output payload
	always_ff @(posedge clk) begin
		if (pop) begin
			ptr_q <= rsp_start(head.code);
			end_q <= rsp_end(head.code);
		end else if (emit && (state_q == BK_TEXT)) begin
			ptr_q <= ptr_q + rom_ptr_t'(1);
		end
		if (emit) begin
			byte_q <= emit_byte;
			last_q <= emit_last;
		end
	end

endmodule

`default_nettype wire

// ===== sv/at_command_responder.sv =====
// ----------------------------------------------------------------------------
// at_command_responder: AT command answering block
// Receives serial bytes on rx, matches each line against a fixed command
// set and sends the canned response on tx.
// ----------------------------------------------------------------------------
// Usage:
//  rx carries one received byte per item, tx one response byte per item;
//  tx_last marks the closing line feed of each response.
//  Ordinary bytes are taken one per cycle while the queue is not full and
//  produce nothing. A carriage return closes the line; its response (the
//  command's response text or ERROR, then CR LF) leaves on tx.
//  The response passes through the queue, the sequencer's ROM pointer and
//  the output register; a response of n text bytes then streams at one byte
//  per cycle while tx is ready, n + 2 bytes in all, and the sequencer passes
//  through its idle state to load the next queued response.
//  Throughput on rx is one byte per cycle while the queue is not full; a
//  two-entry response queue sits between matcher and sequencer, so rx
//  stalls only while two responses wait in the queue, whatever the byte.
//  When tx stalls, the output register holds its byte and the sequencer
//  waits; matching of new lines goes on until the queue fills.
//  Reset clears the line state, the queue and the output register at once.
// ----------------------------------------------------------------------------
`default_nettype none

module at_command_responder (
	input  wire logic clk,
	input  wire logic arst_n,
	at_rx_if.sink     rx,
	at_tx_if.source   tx
);
	import acr_pkg::*;

	acr_job_t push;
	acr_job_t head;
	logic     full;
	logic     pop;

	// line matcher
	acr_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx),
		.full   (full),
		.push   (push)
	);

	// pending responses
	acr_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.full   (full)
	);

	// response sequencer
	acr_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.tx     (tx)
	);

endmodule

`default_nettype wire

// ===== sv/acr_checker.sv =====
// ----------------------------------------------------------------------------
// acr_checker: port level checks of the AT command responder
// Watches the tx channel for held payloads and well formed response ends.
// ----------------------------------------------------------------------------
`default_nettype none

module acr_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        tx_valid,
	input wire logic        tx_ready,
	input wire logic [7:0]  tx_byte,
	input wire logic        tx_last
);
	import acr_pkg::*;

	// a stalled item holds
	a_tx_hold: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && !tx_ready |=> tx_valid && $stable(tx_byte) && $stable(tx_last))
		else $error("tx item changed while stalled");

	// the last item of a response is a line feed
	a_last_lf: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && tx_last |-> tx_byte == CH_LF)
		else $error("tx_last on a byte other than line feed");

	// a response never opens with a line break
	a_next_start: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && tx_ready && tx_last |=>
			!tx_valid || ((tx_byte != CH_CR) && (tx_byte != CH_LF)))
		else $error("response starts with a line break");

	// a carriage return is never followed by another one
	a_lf_last: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && tx_ready && (tx_byte == CH_CR) && !tx_last |=>
			!tx_valid || (tx_byte != CH_CR))
		else $error("two carriage returns in a row");

endmodule

bind at_command_responder acr_checker u_acr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.tx_valid (tx.valid),
	.tx_ready (tx.ready),
	.tx_byte  (tx.tx_byte),
	.tx_last  (tx.tx_last)
);

`default_nettype wire
